FILE: design/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg: shared types and codes of the priority round-robin scheduler
// Holds the command and status codes, the queue entry type and the control
// structs that travel between the sequencer and the cell chain.
// ----------------------------------------------------------------------------
package prrs_pkg;

    localparam int unsigned ID_W   = 4;
    localparam int unsigned PRIO_W = 8;

    typedef enum logic [2:0] {
        CMD_ENQUEUE   = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_SCHEDULE  = 3'd2,
        CMD_START     = 3'd3,
        CMD_IRQ_ENTER = 3'd4,
        CMD_IRQ_EXIT  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_DUP_FULL    = 3'd1,
        STAT_NOT_FOUND   = 3'd2,
        STAT_EMPTY       = 3'd3,
        STAT_NOT_STARTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } chain_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCHED,
        ST_REQUEUE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Control from sequencer to the chain
    typedef struct packed {
        chain_op_t         op;
        logic              pop;      // remove the head regardless of id
        logic [ID_W-1:0]   key_id;
        logic [PRIO_W-1:0] key_prio;
    } chain_ctrl_t;

    // Status from chain back to sequencer
    typedef struct packed {
        logic   any_hit;
        entry_t head;
    } chain_stat_t;

    localparam logic [PRIO_W-1:0] PRIO_IDLE = 8'd255;
    localparam logic [7:0]        NEST_MAX  = 8'd255;

endpackage

FILE: design/prrs_cell.sv
// ----------------------------------------------------------------------------
// prrs_cell: one slot of the sorted ready queue
// Holds one entry, compares it with the key and takes its neighbor's entry
// on an insert (shift toward the tail) or a remove (shift toward the head).
// ----------------------------------------------------------------------------
module prrs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prrs_pkg::chain_op_t  op,
    input  logic [3:0]           key_id,
    input  logic [7:0]           key_prio,
    input  prrs_pkg::entry_t     prev_entry,
    input  prrs_pkg::entry_t     next_entry,
    input  logic                 prev_go,
    input  logic                 prev_after,
    output prrs_pkg::entry_t     entry,
    output logic                 go,
    output logic                 after
);

    prrs_pkg::entry_t entry_reg, entry_next;
    logic hit;

    assign hit   = entry_reg.valid && (entry_reg.id == key_id);
    assign after = prev_after | hit;
    // slot lies at or behind the insertion point
    assign go    = !entry_reg.valid || (entry_reg.prio > key_prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (op)
            prrs_pkg::OP_INSERT: begin
                if (go) begin
                    if (prev_go) begin
                        entry_next = prev_entry;
                    end else begin
                        entry_next = '{valid: 1'b1, id: key_id, prio: key_prio};
                    end
                end
            end
            prrs_pkg::OP_REMOVE: begin
                if (after) begin
                    entry_next = next_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.id   <= entry_next.id;
        entry_reg.prio <= entry_next.prio;
    end

endmodule

FILE: design/prrs_chain.sv
// ----------------------------------------------------------------------------
// prrs_chain: row of queue cells
// Links the cells head to tail and reports the head and any id match.
// ----------------------------------------------------------------------------
module prrs_chain #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  prrs_pkg::chain_ctrl_t  ctrl,
    output prrs_pkg::chain_stat_t  stat
);

    prrs_pkg::entry_t entries [DEPTH];
    logic             go_v    [DEPTH];
    logic             after_v [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        prrs_pkg::entry_t prev_e, next_e;
        logic             prev_g, prev_a;
        if (i == 0) begin : g_head
            assign prev_e = '0;
            assign prev_g = 1'b0;
            assign prev_a = ctrl.pop;
        end else begin : g_mid
            assign prev_e = entries[i-1];
            assign prev_g = go_v[i-1];
            assign prev_a = after_v[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_body
            assign next_e = entries[i+1];
        end

        prrs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (ctrl.op),
            .key_id     (ctrl.key_id),
            .key_prio   (ctrl.key_prio),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .prev_go    (prev_g),
            .prev_after (prev_a),
            .entry      (entries[i]),
            .go         (go_v[i]),
            .after      (after_v[i])
        );
    end

    assign stat.any_hit = after_v[DEPTH-1];
    assign stat.head    = entries[0];

endmodule

FILE: design/priority_round_robin_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_top: hardware thread scheduler
// Sorted ready queue in a chain of cells plus a small command sequencer.
// ----------------------------------------------------------------------------
// One command is taken per transfer and yields exactly one result transfer.
// The ready queue is a row of MAX_THREADS cells kept sorted by priority
// (0 highest), first-in first-out among equals; every cell compares itself
// with the key in parallel, so an insert, a removal or a head pop is a
// single chain step. A command runs as a short sequence of chain steps:
// enqueue, remove, start and interrupt enter have a command step and a
// result step; schedule, interrupt exit and an enqueue that schedules add
// a schedule step, and a preemption that pops the head adds a requeue step
// for the old thread (an enqueue that schedules and preempts included).
// s_ready is low while a command runs; the result register lets the next
// command start while the previous result still waits on m_ready.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_top #(
    parameter int unsigned MAX_THREADS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [3:0] s_thread_id,
    input  logic [7:0] s_priority_req,
    input  logic       s_timer_tick,
    input  logic       s_current_leaving,
    input  logic       s_then_schedule,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_switched,
    output logic [3:0] m_old_thread,
    output logic [3:0] m_new_thread,
    output logic [4:0] m_queue_count,
    output logic       m_in_interrupt
);

    localparam int unsigned CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_THREADS);
    localparam logic [7:0] NEST_MAX_L = prrs_pkg::NEST_MAX;

    prrs_pkg::state_t      state_reg, state_next;
    prrs_pkg::chain_ctrl_t ctrl;
    prrs_pkg::chain_stat_t cstat;

    // captured command
    logic [2:0] cmd_reg;
    logic [3:0] id_reg;
    logic [7:0] prio_reg;
    logic       tick_reg, leave_reg, then_reg;

    // scheduler state
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    run_id_reg, run_id_next;
    logic [7:0]    run_prio_reg, run_prio_next;
    logic          started_reg, started_next;
    logic [7:0]    nest_reg, nest_next;
    logic [3:0]    old_reg;
    logic [3:0]    hold_id_reg, hold_id_next;
    logic [7:0]    hold_prio_reg, hold_prio_next;
    prrs_pkg::status_t status_reg, status_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg;
    logic              m_switched_reg;
    logic [3:0]        m_old_reg, m_new_reg;
    logic [4:0]        m_count_reg;
    logic              m_irq_reg;

    logic accept, out_free, full, enq_ok, tick_eff, preempt, sched_more;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == prrs_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == COUNT_MAX);
    assign enq_ok   = !cstat.any_hit && !full;
    // the schedule that follows an enqueue never sees a tick
    assign tick_eff = tick_reg && (cmd_reg != prrs_pkg::CMD_ENQUEUE);
    assign preempt  = cstat.head.valid &&
                      (tick_eff ? (cstat.head.prio <= run_prio_reg)
                                : (cstat.head.prio <  run_prio_reg));
    assign sched_more = enq_ok && then_reg && started_reg && (nest_reg == 8'd0);

    prrs_chain #(.DEPTH(MAX_THREADS)) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (cstat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                if (accept) state_next = prrs_pkg::ST_CMD;
            end
            prrs_pkg::ST_CMD: begin
                unique case (cmd_reg)
                    prrs_pkg::CMD_ENQUEUE:
                        state_next = sched_more ? prrs_pkg::ST_SCHED : prrs_pkg::ST_DONE;
                    prrs_pkg::CMD_SCHEDULE, prrs_pkg::CMD_IRQ_EXIT:
                        state_next = prrs_pkg::ST_SCHED;
                    default: state_next = prrs_pkg::ST_DONE;
                endcase
            end
            prrs_pkg::ST_SCHED: begin
                state_next = (started_reg && !leave_reg && preempt) ?
                             prrs_pkg::ST_REQUEUE : prrs_pkg::ST_DONE;
            end
            prrs_pkg::ST_REQUEUE: state_next = prrs_pkg::ST_DONE;
            prrs_pkg::ST_DONE: begin
                if (out_free) state_next = prrs_pkg::ST_IDLE;
            end
            default: state_next = prrs_pkg::ST_IDLE;
        endcase
    end

    // chain control and datapath updates
    always_comb begin
        ctrl           = '{op: prrs_pkg::OP_NOP, pop: 1'b0,
                           key_id: id_reg, key_prio: prio_reg};
        count_next     = count_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        started_next   = started_reg;
        nest_next      = nest_reg;
        hold_id_next   = hold_id_reg;
        hold_prio_next = hold_prio_reg;
        status_next    = status_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                status_next = prrs_pkg::STAT_OK;
            end
            prrs_pkg::ST_CMD: begin
                unique case (cmd_reg)
                    prrs_pkg::CMD_ENQUEUE: begin
                        if (enq_ok) begin
                            ctrl.op    = prrs_pkg::OP_INSERT;
                            count_next = count_reg + 1'b1;
                        end else begin
                            status_next = prrs_pkg::STAT_DUP_FULL;
                        end
                    end
                    prrs_pkg::CMD_REMOVE: begin
                        ctrl.op = prrs_pkg::OP_REMOVE;
                        if (cstat.any_hit) begin
                            count_next = count_reg - 1'b1;
                        end else begin
                            status_next = prrs_pkg::STAT_NOT_FOUND;
                        end
                    end
                    prrs_pkg::CMD_START: begin
                        started_next = 1'b1;
                        if (cstat.head.valid) begin
                            ctrl.op       = prrs_pkg::OP_REMOVE;
                            ctrl.pop      = 1'b1;
                            run_id_next   = cstat.head.id;
                            run_prio_next = cstat.head.prio;
                            count_next    = count_reg - 1'b1;
                        end else begin
                            status_next = prrs_pkg::STAT_EMPTY;
                        end
                    end
                    prrs_pkg::CMD_IRQ_ENTER: begin
                        if (nest_reg != NEST_MAX_L) nest_next = nest_reg + 8'd1;
                    end
                    prrs_pkg::CMD_IRQ_EXIT: begin
                        if (nest_reg != 8'd0) nest_next = nest_reg - 8'd1;
                    end
                    default: status_next = prrs_pkg::STAT_OK;
                endcase
            end
            prrs_pkg::ST_SCHED: begin
                if (!started_reg) begin
                    if (cmd_reg != prrs_pkg::CMD_ENQUEUE)
                        status_next = prrs_pkg::STAT_NOT_STARTED;
                end else if (leave_reg ? cstat.head.valid : preempt) begin
                    // take the head, keep the old thread for requeue
                    ctrl.op        = prrs_pkg::OP_REMOVE;
                    ctrl.pop       = 1'b1;
                    hold_id_next   = run_id_reg;
                    hold_prio_next = run_prio_reg;
                    run_id_next    = cstat.head.id;
                    run_prio_next  = cstat.head.prio;
                    count_next     = count_reg - 1'b1;
                end else if (leave_reg && (cmd_reg != prrs_pkg::CMD_ENQUEUE)) begin
                    status_next = prrs_pkg::STAT_EMPTY;
                end
            end
            prrs_pkg::ST_REQUEUE: begin
                ctrl.key_id   = hold_id_reg;
                ctrl.key_prio = hold_prio_reg;
                // drop the requeue when the old id already waits in the queue
                if (!cstat.any_hit) begin
                    ctrl.op    = prrs_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            prrs_pkg::ST_DONE: begin
                status_next = status_reg;
            end
            default: status_next = status_reg;
        endcase
    end

    assign m_valid_next = (state_reg == prrs_pkg::ST_DONE && out_free) ||
                          (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= prrs_pkg::ST_IDLE;
            count_reg    <= '0;
            run_id_reg   <= 4'd0;
            run_prio_reg <= prrs_pkg::PRIO_IDLE;
            started_reg  <= 1'b0;
            nest_reg     <= 8'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            run_id_reg   <= run_id_next;
            run_prio_reg <= run_prio_next;
            started_reg  <= started_next;
            nest_reg     <= nest_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers: capture on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_cmd;
            id_reg    <= s_thread_id;
            prio_reg  <= s_priority_req;
            tick_reg  <= s_timer_tick;
            leave_reg <= s_current_leaving;
            then_reg  <= s_then_schedule;
            old_reg   <= run_id_reg;
        end
        hold_id_reg   <= hold_id_next;
        hold_prio_reg <= hold_prio_next;
        status_reg    <= status_next;
        if (state_reg == prrs_pkg::ST_DONE && out_free) begin
            m_status_reg   <= status_reg;
            m_switched_reg <= (run_id_reg != old_reg);
            m_old_reg      <= old_reg;
            m_new_reg      <= run_id_reg;
            m_count_reg    <= 5'(count_reg);
            m_irq_reg      <= (nest_reg != 8'd0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_switched     = m_switched_reg;
    assign m_old_thread   = m_old_reg;
    assign m_new_thread   = m_new_reg;
    assign m_queue_count  = m_count_reg;
    assign m_in_interrupt = m_irq_reg;

    // the queue never holds more entries than cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("queue count exceeds depth");

    // head cell is occupied exactly when the count is nonzero
    a_head_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cstat.head.valid == (count_reg != '0))
        else $error("head valid disagrees with count");

    // a requeue step always goes straight to the result step
    a_requeue_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == prrs_pkg::ST_REQUEUE |=> state_reg == prrs_pkg::ST_DONE)
        else $error("requeue not followed by result");

    // a transfer in starts the command step
    a_accept_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == prrs_pkg::ST_CMD)
        else $error("accepted command not started");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the priority round-robin scheduler
// A clocked driver sends scheduler commands from a queue with random gaps; a
// clocked monitor pulls results with random stalls and compares them field
// by field against a scoreboard model of the ready queue and running thread.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NTHR      = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 20;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] tid;
        logic [7:0] prio;
        logic       tick;
        logic       leaving;
        logic       then_sched;
    } sched_cmd_t;

    localparam int CMD_BITS = $bits(sched_cmd_t);

    typedef struct packed {
        logic [2:0] status;
        logic       switched;
        logic [3:0] old_thr;
        logic [3:0] new_thr;
        logic [4:0] qcount;
        logic       in_irq;
    } sched_res_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_cmd;
    logic [3:0] s_thread_id;
    logic [7:0] s_priority_req;
    logic       s_timer_tick;
    logic       s_current_leaving;
    logic       s_then_schedule;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic       m_switched;
    logic [3:0] m_old_thread;
    logic [3:0] m_new_thread;
    logic [4:0] m_queue_count;
    logic       m_in_interrupt;

    priority_round_robin_scheduler_top #(.MAX_THREADS(NTHR)) dut (.*);

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Scoreboard model of the scheduler state
    logic [3:0] rq_id [NTHR];
    logic [7:0] rq_prio [NTHR];
    int         rq_len;
    logic [3:0] run_id;
    logic [7:0] run_prio;
    bit         started;
    logic [7:0] nest;

    sched_cmd_t pending_cmds[$];
    sched_res_t expected_res[$];
    int         errors;
    int         hold_off;   // long receiver stall, set by the stimulus

    function automatic int rq_find(logic [3:0] id);
        for (int i = 0; i < rq_len; i++)
            if (rq_id[i] == id) return i;
        return rq_len;
    endfunction

    function automatic void rq_drop(int pos);
        if (pos >= rq_len) return;
        for (int i = pos; i + 1 < rq_len; i++) begin
            rq_id[i]   = rq_id[i+1];
            rq_prio[i] = rq_prio[i+1];
        end
        rq_len--;
    endfunction

    function automatic logic [2:0] rq_insert(logic [3:0] id, logic [7:0] pr);
        int pos;
        if (rq_find(id) < rq_len || rq_len >= NTHR) return prrs_pkg::STAT_DUP_FULL;
        pos = 0;
        while (pos < rq_len && rq_prio[pos] <= pr) pos++;
        for (int i = rq_len; i > pos; i--) begin
            rq_id[i]   = rq_id[i-1];
            rq_prio[i] = rq_prio[i-1];
        end
        rq_id[pos]   = id;
        rq_prio[pos] = pr;
        rq_len++;
        return prrs_pkg::STAT_OK;
    endfunction

    function automatic void take_head();
        run_id   = rq_id[0];
        run_prio = rq_prio[0];
        rq_drop(0);
    endfunction

    function automatic logic [2:0] reschedule(bit tick, bit leaving);
        int         lim;
        bit         ok;
        logic [3:0] oid;
        logic [7:0] opr;
        logic [2:0] st;
        if (!started) return prrs_pkg::STAT_NOT_STARTED;
        if (leaving) begin
            if (rq_len == 0) return prrs_pkg::STAT_EMPTY;
            take_head();
            return prrs_pkg::STAT_OK;
        end
        ok  = tick || run_prio > 0;
        lim = tick ? int'(run_prio) : int'(run_prio) - 1;
        if (ok && rq_len > 0 && int'(rq_prio[0]) <= lim) begin
            oid = run_id;
            opr = run_prio;
            take_head();
            st = rq_insert(oid, opr);
        end
        return prrs_pkg::STAT_OK;
    endfunction

    function automatic sched_res_t predict_result(sched_cmd_t c);
        sched_res_t r;
        logic [3:0] prev;
        logic [2:0] st;
        logic [2:0] dummy;
        int         pos;
        prev = run_id;
        st   = prrs_pkg::STAT_OK;
        case (c.cmd)
            prrs_pkg::CMD_ENQUEUE: begin
                st = rq_insert(c.tid, c.prio);
                if (st == prrs_pkg::STAT_OK && c.then_sched && started && nest == 0)
                    dummy = reschedule(1'b0, c.leaving);
            end
            prrs_pkg::CMD_REMOVE: begin
                pos = rq_find(c.tid);
                if (pos < rq_len) rq_drop(pos);
                else st = prrs_pkg::STAT_NOT_FOUND;
            end
            prrs_pkg::CMD_SCHEDULE: st = reschedule(c.tick, c.leaving);
            prrs_pkg::CMD_START: begin
                started = 1'b1;
                if (rq_len > 0) take_head();
                else st = prrs_pkg::STAT_EMPTY;
            end
            prrs_pkg::CMD_IRQ_ENTER: if (nest != prrs_pkg::NEST_MAX) nest++;
            prrs_pkg::CMD_IRQ_EXIT: begin
                if (nest != 0) nest--;
                st = reschedule(c.tick, c.leaving);
            end
            default: ;
        endcase
        r.status   = st;
        r.switched = run_id != prev;
        r.old_thr  = prev;
        r.new_thr  = run_id;
        r.qcount   = 5'(rq_len);
        r.in_irq   = nest != 0;
        return r;
    endfunction

    function automatic sched_cmd_t mk_cmd(logic [2:0] op, logic [3:0] id,
                                          logic [7:0] pr, bit tk, bit lv,
                                          bit ts);
        sched_cmd_t c;
        c.cmd = op; c.tid = id; c.prio = pr;
        c.tick = tk; c.leaving = lv; c.then_sched = ts;
        return c;
    endfunction

    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t c;
        int         w;
        c = sched_cmd_t'(CMD_BITS'($urandom));
        c.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        w = $urandom_range(0, 99);
        if (w < 40)      c.cmd = prrs_pkg::CMD_ENQUEUE;
        else if (w < 52) c.cmd = prrs_pkg::CMD_REMOVE;
        else if (w < 72) c.cmd = prrs_pkg::CMD_SCHEDULE;
        else if (w < 76) c.cmd = prrs_pkg::CMD_START;
        else if (w < 86) c.cmd = prrs_pkg::CMD_IRQ_ENTER;
        else if (w < 97) c.cmd = prrs_pkg::CMD_IRQ_EXIT;
        else             c.cmd = 3'($urandom_range(6, 7));
        c.leaving = $urandom_range(0, 4) == 0;
        return c;
    endfunction

    // Driver: present one command per transfer, with a random gap before each
    int gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap     <= $urandom_range(0, 15);
        end else if (s_valid && !s_ready) begin
            // hold until the transfer happens
        end else if (gap > 0 || pending_cmds.size() == 0) begin
            s_valid <= 1'b0;
            if (gap > 0) gap <= gap - 1;
        end else begin
            sched_cmd_t c;
            c = pending_cmds.pop_front();
            s_valid           <= 1'b1;
            s_cmd             <= c.cmd;
            s_thread_id       <= c.tid;
            s_priority_req    <= c.prio;
            s_timer_tick      <= c.tick;
            s_current_leaving <= c.leaving;
            s_then_schedule   <= c.then_sched;
            gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        end
    end

    // Predict on every accepted input transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_res.push_back(predict_result(mk_cmd(s_cmd, s_thread_id,
                s_priority_req, s_timer_tick, s_current_leaving, s_then_schedule)));
    end

    // Monitor: random stall per result, compare every field on transfer
    int stall;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall   <= 0;
        end else begin
            if (m_valid && m_ready) begin
                sched_res_t a, e;
                a = {m_status, m_switched, m_old_thread, m_new_thread,
                     m_queue_count, m_in_interrupt};
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, a);
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    if (a.status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                        errors++;
                    end
                    if (a.switched !== e.switched) begin
                        $display("%0t: switched exp %0d got %0d", $time, e.switched,
                                 a.switched);
                        errors++;
                    end
                    if (a.old_thr !== e.old_thr) begin
                        $display("%0t: old_thread exp %0d got %0d", $time, e.old_thr,
                                 a.old_thr);
                        errors++;
                    end
                    if (a.new_thr !== e.new_thr) begin
                        $display("%0t: new_thread exp %0d got %0d", $time, e.new_thr,
                                 a.new_thr);
                        errors++;
                    end
                    if (a.qcount !== e.qcount) begin
                        $display("%0t: queue_count exp %0d got %0d", $time, e.qcount,
                                 a.qcount);
                        errors++;
                    end
                    if (a.in_irq !== e.in_irq) begin
                        $display("%0t: in_interrupt exp %0d got %0d", $time, e.in_irq,
                                 a.in_irq);
                        errors++;
                    end
                end
            end
            // Draw a new stall after each transfer; the long hold-off wins
            if (hold_off > 0) begin
                m_ready  <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (m_valid && m_ready) begin
                stall   <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall   <= stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    int idle_cyc;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || hold_off > 0)
            idle_cyc <= 0;
        else if (pending_cmds.size() != 0 || expected_res.size() != 0 || s_valid) begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG_MAX) begin
                $display("%0t: watchdog expired", $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        hold_off = 0;
        rq_len = 0;
        run_id = '0;
        run_prio = prrs_pkg::PRIO_IDLE;
        started = 1'b0;
        nest = '0;
        idle_cyc = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_cmd = '0;
        s_thread_id = '0;
        s_priority_req = '0;
        s_timer_tick = 1'b0;
        s_current_leaving = 1'b0;
        s_then_schedule = 1'b0;

        // Directed: not-started paths, empty start, full and duplicate queue,
        // preemption, schedule on a tick, remove, nesting, undefined opcodes
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_SCHEDULE, 0, 0, 1, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_IRQ_EXIT, 0, 0, 0, 1, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_START, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_SCHEDULE, 0, 0, 0, 1, 0));
        for (int i = 0; i < 16; i++)
            pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_ENQUEUE, 4'(15 - i),
                                          (i == 0) ? 8'd255 : 8'(i * 16), 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_ENQUEUE, 3, 0, 0, 0, 1));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_REMOVE, 15, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_ENQUEUE, 14, 1, 0, 0, 1));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_START, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_SCHEDULE, 0, 0, 1, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_REMOVE, 15, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_IRQ_ENTER, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_ENQUEUE, 15, 0, 0, 0, 1));
        pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_IRQ_EXIT, 0, 0, 1, 0, 0));
        pending_cmds.push_back(mk_cmd(3'd6, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(3'd7, 15, 255, 1, 1, 1));
        for (int i = 0; i < 260; i++)
            pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_IRQ_ENTER, 0, 0, 0, 0, 0));
        for (int i = 0; i < 258; i++)
            pending_cmds.push_back(mk_cmd(prrs_pkg::CMD_IRQ_EXIT, 0, 0, 0, 0, 0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Random phase; drain the queue through leaving schedules now and then
        for (int i = 0; i < 740; i++) begin
            pending_cmds.push_back(rand_cmd());
            if (i == 600) begin
                // wait until the driver catches up, then stall the receiver long
                while (pending_cmds.size() > 40) @(posedge aclk);
                hold_off = 300;
            end
            if (pending_cmds.size() > 60) @(posedge aclk);
        end

        while (pending_cmds.size() != 0 || s_valid) @(posedge aclk);
        while (expected_res.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/prrs_pkg.sv
design/prrs_cell.sv
design/prrs_chain.sv
design/priority_round_robin_scheduler_top.sv
dv/tb_top.sv
